// ----- sv/p2t2_pkg.sv -----
`timescale 1ns / 1ps
package p2t2_pkg;

  localparam int PARTIAL_ROUNDS_DEF   = 50;
  localparam int HALF_FULL_ROUNDS_DEF = 3;

  localparam int ELEM_W = 256;

  localparam logic [ELEM_W-1:0] MODULUS =
    256'h30644e72e131a029b85045b68181585d2833e84879b9709143e1f593f0000001;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_PERMUTE = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [5:0]  key_index;
    logic [63:0] left_in_0;
    logic [63:0] left_in_1;
    logic [63:0] left_in_2;
    logic [63:0] left_in_3;
    logic [63:0] right_in_0;
    logic [63:0] right_in_1;
    logic [63:0] right_in_2;
    logic [63:0] right_in_3;
  } in_beat_t;

  typedef struct packed {
    logic        ok;
    logic [63:0] left_out_0;
    logic [63:0] left_out_1;
    logic [63:0] left_out_2;
    logic [63:0] left_out_3;
    logic [63:0] right_out_0;
    logic [63:0] right_out_1;
    logic [63:0] right_out_2;
    logic [63:0] right_out_3;
  } out_beat_t;

endpackage

// ----- sv/poseidon2_t2_permutation_top.sv -----
`timescale 1ns / 1ps
// Poseidon2 width-2 permutation over the BN254 scalar field, built around a single
// 256-bit modular adder that a small sequencer reuses for every field addition. Field
// products are formed by double-and-add over the multiplier's 256 bits. A permutation
// runs 62 S-boxes of three products each, plus the round-key adds and matrix adds. A
// load beat reduces its key by repeated subtraction of the modulus. The block takes one
// beat at a time; a finished result waits in the output register while the next beat
// enters. Keys live in a memory of 4*HALF_FULL_ROUNDS+PARTIAL_ROUNDS slots of
// 256 bits; every slot must be loaded before the first permute.
module poseidon2_t2_permutation_top #(
  parameter int PARTIAL_ROUNDS   = p2t2_pkg::PARTIAL_ROUNDS_DEF,
  parameter int HALF_FULL_ROUNDS = p2t2_pkg::HALF_FULL_ROUNDS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  p2t2_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output p2t2_pkg::out_beat_t out_data
);
  import p2t2_pkg::*;

  localparam int KEY_SLOTS = 4 * HALF_FULL_ROUNDS + PARTIAL_ROUNDS;
  localparam int AW = $clog2(KEY_SLOTS);
  localparam int SW = $clog2(KEY_SLOTS + 1);
  localparam logic [SW-1:0] PRE_END   = SW'(2 * HALF_FULL_ROUNDS);
  localparam logic [SW-1:0] POST_BASE = SW'(2 * HALF_FULL_ROUNDS + PARTIAL_ROUNDS);
  localparam logic [SW-1:0] SLOT_END  = SW'(KEY_SLOTS);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_REDUCE = 4'd1;
  localparam logic [3:0] ST_CHECK  = 4'd2;
  localparam logic [3:0] ST_MAT    = 4'd3;
  localparam logic [3:0] ST_FETCH  = 4'd4;
  localparam logic [3:0] ST_ADDK   = 4'd5;
  localparam logic [3:0] ST_POW    = 4'd6;
  localparam logic [3:0] ST_MUL    = 4'd7;
  localparam logic [3:0] ST_OUT    = 4'd8;

  logic [3:0]        state;
  logic [ELEM_W-1:0] a, b, t, acc, mul_m, mul_q, key_q;
  logic [SW-1:0]     slot;
  logic [AW-1:0]     ld_addr;
  logic              lane, full, dbl, ok_r;
  logic [1:0]        step, pstep;
  logic [7:0]        bitc;

  logic [ELEM_W-1:0] key_mem [KEY_SLOTS];

  // shared modular adder
  logic [ELEM_W-1:0] op_x, op_y, add_r, lane_x;
  logic [ELEM_W:0]   sum;
  logic [ELEM_W+1:0] diff;
  logic              ge;

  assign lane_x = lane ? b : a;

  always_comb begin
    op_x = t;
    op_y = '0;
    unique case (state)
      ST_ADDK: begin
        op_x = lane_x;
        op_y = key_q;
      end
      ST_MUL: begin
        op_x = acc;
        op_y = dbl ? acc : mul_m;
      end
      ST_MAT: begin
        unique case (step)
          2'd0: begin op_x = a; op_y = b; end
          2'd1: begin op_x = a; op_y = t; end
          2'd2: begin op_x = b; op_y = full ? t : b; end
          2'd3: begin op_x = b; op_y = t; end
        endcase
      end
      default: begin end
    endcase
  end

  assign sum   = {1'b0, op_x} + {1'b0, op_y};
  assign diff  = {1'b0, sum} - {2'b00, MODULUS};
  assign ge    = !diff[ELEM_W+1];
  assign add_r = ge ? diff[ELEM_W-1:0] : sum[ELEM_W-1:0];

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (state == ST_REDUCE && !ge) begin
      key_mem[ld_addr] <= t;
    end
    key_q <= key_mem[slot[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_data.cmd == CMD_PERMUTE) begin
              a <= {in_data.left_in_3, in_data.left_in_2, in_data.left_in_1,
                    in_data.left_in_0};
              b <= {in_data.right_in_3, in_data.right_in_2, in_data.right_in_1,
                    in_data.right_in_0};
              state <= ST_CHECK;
            end else if (int'(in_data.key_index) < KEY_SLOTS) begin
              t <= {in_data.left_in_3, in_data.left_in_2, in_data.left_in_1,
                    in_data.left_in_0};
              ld_addr <= AW'(in_data.key_index);
              state   <= ST_REDUCE;
            end
          end
        end
        ST_REDUCE: begin
          if (ge) begin
            t <= add_r;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_CHECK: begin
          full <= 1'b1;
          step <= 2'd0;
          slot <= '0;
          lane <= 1'b0;
          if (a < MODULUS && b < MODULUS) begin
            ok_r  <= 1'b1;
            state <= ST_MAT;
          end else begin
            ok_r  <= 1'b0;
            a     <= '0;
            b     <= '0;
            state <= ST_OUT;
          end
        end
        ST_MAT: begin
          step <= step + 2'd1;
          unique case (step)
            2'd0: t <= add_r;
            2'd1: a <= add_r;
            2'd2, 2'd3: b <= add_r;
          endcase
          if ((step == 2'd2 && full) || step == 2'd3) begin
            state <= (slot == SLOT_END) ? ST_OUT : ST_FETCH;
          end
        end
        ST_FETCH: begin
          state <= ST_ADDK;
        end
        ST_ADDK: begin
          if (lane) begin
            b <= add_r;
          end else begin
            a <= add_r;
          end
          full  <= (slot < PRE_END) || (slot >= POST_BASE);
          slot  <= slot + SW'(1);
          pstep <= 2'd0;
          state <= ST_POW;
        end
        ST_POW: begin
          dbl   <= 1'b1;
          bitc  <= 8'd255;
          acc   <= '0;
          pstep <= pstep + 2'd1;
          state <= ST_MUL;
          unique case (pstep)
            2'd0: begin mul_m <= lane_x; mul_q <= lane_x; end
            2'd1: begin mul_m <= acc;    mul_q <= acc;    end
            2'd2: begin mul_m <= acc;    mul_q <= lane_x; end
            2'd3: begin
              if (lane) begin
                b <= acc;
              end else begin
                a <= acc;
              end
              lane  <= full && !lane;
              step  <= 2'd0;
              state <= (full && !lane) ? ST_FETCH : ST_MAT;
            end
          endcase
        end
        ST_MUL: begin
          acc <= add_r;
          if (dbl && mul_q[bitc]) begin
            dbl <= 1'b0;
          end else begin
            dbl <= 1'b1;
            if (bitc == 8'd0) begin
              state <= ST_POW;
            end else begin
              bitc <= bitc - 8'd1;
            end
          end
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_data.ok          <= ok_r;
            out_data.left_out_0  <= a[63:0];
            out_data.left_out_1  <= a[127:64];
            out_data.left_out_2  <= a[191:128];
            out_data.left_out_3  <= a[255:192];
            out_data.right_out_0 <= b[63:0];
            out_data.right_out_1 <= b[127:64];
            out_data.right_out_2 <= b[191:128];
            out_data.right_out_3 <= b[255:192];
            state                <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_FETCH |-> slot < SLOT_END)
    else $error("key fetch beyond last slot");

  a_mul_bit: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL && !dbl |-> mul_q[bitc])
    else $error("add step without multiplier bit");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.ok |->
      out_data.left_out_0 == 64'd0 && out_data.left_out_1 == 64'd0 &&
      out_data.left_out_2 == 64'd0 && out_data.left_out_3 == 64'd0 &&
      out_data.right_out_0 == 64'd0 && out_data.right_out_1 == 64'd0 &&
      out_data.right_out_2 == 64'd0 && out_data.right_out_3 == 64'd0)
    else $error("rejected beat carries nonzero limbs");
`endif

endmodule

// ----- verif/poseidon2_t2_permutation_checker.sv -----
`timescale 1ns / 1ps
module poseidon2_t2_permutation_checker #(
  parameter int PARTIAL_ROUNDS   = p2t2_pkg::PARTIAL_ROUNDS_DEF,
  parameter int HALF_FULL_ROUNDS = p2t2_pkg::HALF_FULL_ROUNDS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  p2t2_pkg::in_beat_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  p2t2_pkg::out_beat_t out_data,
  output int                  errors,
  output int                  pending
);
  import p2t2_pkg::*;

  localparam int KEY_SLOTS = 4 * HALF_FULL_ROUNDS + PARTIAL_ROUNDS;
  localparam int POST_BASE = 2 * HALF_FULL_ROUNDS + PARTIAL_ROUNDS;

  typedef logic [ELEM_W-1:0] elem_t;

  elem_t     round_keys [KEY_SLOTS];
  out_beat_t expected_results[$];

  function automatic elem_t mod_add(elem_t a, elem_t b);
    logic [ELEM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, MODULUS}) s = s - {1'b0, MODULUS};
    return s[ELEM_W-1:0];
  endfunction

  function automatic elem_t mod_mul(elem_t a, elem_t b);
    logic [2*ELEM_W-1:0] w;
    w = {{ELEM_W{1'b0}}, a} * {{ELEM_W{1'b0}}, b};
    w = w % {{ELEM_W{1'b0}}, MODULUS};
    return w[ELEM_W-1:0];
  endfunction

  function automatic elem_t sbox(elem_t x);
    elem_t x2, x4;
    x2 = mod_mul(x, x);
    x4 = mod_mul(x2, x2);
    return mod_mul(x4, x);
  endfunction

  function automatic out_beat_t permute(elem_t l, elem_t r);
    out_beat_t res;
    elem_t t;
    res = '0;
    if (l >= MODULUS || r >= MODULUS) return res;
    t = mod_add(l, r); l = mod_add(l, t); r = mod_add(r, t);
    for (int i = 0; i < 2 * HALF_FULL_ROUNDS + PARTIAL_ROUNDS; i++) begin
      if (i < HALF_FULL_ROUNDS || i >= HALF_FULL_ROUNDS + PARTIAL_ROUNDS) begin
        int slot;
        slot = (i < HALF_FULL_ROUNDS) ? 2 * i
             : POST_BASE + 2 * (i - HALF_FULL_ROUNDS - PARTIAL_ROUNDS);
        l = sbox(mod_add(l, round_keys[slot]));
        r = sbox(mod_add(r, round_keys[slot+1]));
        t = mod_add(l, r); l = mod_add(l, t); r = mod_add(r, t);
      end else begin
        l = sbox(mod_add(l, round_keys[2 * HALF_FULL_ROUNDS + i - HALF_FULL_ROUNDS]));
        t = mod_add(l, r); l = mod_add(l, t); r = mod_add(mod_add(r, r), t);
      end
    end
    res.ok = 1'b1;
    {res.left_out_3, res.left_out_2, res.left_out_1, res.left_out_0} = l;
    {res.right_out_3, res.right_out_2, res.right_out_1, res.right_out_0} = r;
    return res;
  endfunction

  function automatic int check_field(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $error("%s: expected %h, got %h", name, e, a);
      return 1;
    end
    return 0;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    if (rst) begin
      errors <= 0;
      expected_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        elem_t l, r;
        l = {in_data.left_in_3, in_data.left_in_2, in_data.left_in_1, in_data.left_in_0};
        r = {in_data.right_in_3, in_data.right_in_2, in_data.right_in_1,
             in_data.right_in_0};
        if (in_data.cmd == CMD_LOAD) begin
          if (in_data.key_index < KEY_SLOTS) begin
            while (l >= MODULUS) l = l - MODULUS;
            round_keys[in_data.key_index] = l;
          end
        end else begin
          expected_results.push_back(permute(l, r));
        end
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no expectation pending");
          errors <= errors + 1;
        end else begin
          out_beat_t e;
          int n;
          e = expected_results.pop_front();
          n = check_field("ok", 64'(e.ok), 64'(out_data.ok));
          n += check_field("left_out_0", e.left_out_0, out_data.left_out_0);
          n += check_field("left_out_1", e.left_out_1, out_data.left_out_1);
          n += check_field("left_out_2", e.left_out_2, out_data.left_out_2);
          n += check_field("left_out_3", e.left_out_3, out_data.left_out_3);
          n += check_field("right_out_0", e.right_out_0, out_data.right_out_0);
          n += check_field("right_out_1", e.right_out_1, out_data.right_out_1);
          n += check_field("right_out_2", e.right_out_2, out_data.right_out_2);
          n += check_field("right_out_3", e.right_out_3, out_data.right_out_3);
          errors <= errors + n;
        end
      end
    end
  end

endmodule

// ----- verif/poseidon2_t2_permutation_top_test.sv -----
`timescale 1ns / 1ps
module poseidon2_t2_permutation_top_test;
  import p2t2_pkg::*;

  localparam int  KEY_SLOTS   = 4 * HALF_FULL_ROUNDS_DEF + PARTIAL_ROUNDS_DEF;
  localparam int  ITEMS       = 750;
  localparam int  LONG_HOLD   = 200000;
  localparam longint LIMIT    = 40000000;

  typedef logic [ELEM_W-1:0] elem_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;
  int        errors;
  int        pending;
  bit        no_idle = 1'b0;
  int        results_seen = 0;
  int        loads = 0;
  int        permutes = 0;
  longint    cycles = 0;

  poseidon2_t2_permutation_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  poseidon2_t2_permutation_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .errors(errors), .pending(pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic elem_t rand_elem(bit canonical);
    elem_t v;
    v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if (canonical) v[255:192] = v[255:192] % MODULUS[255:192];
    return v;
  endfunction

  task automatic send(in_beat_t b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    if (b.cmd == CMD_LOAD) loads++;
    else permutes++;
  endtask

  task automatic load_key(logic [5:0] idx, elem_t k);
    in_beat_t b;
    b = '0;
    b.cmd = CMD_LOAD;
    b.key_index = idx;
    {b.left_in_3, b.left_in_2, b.left_in_1, b.left_in_0} = k;
    {b.right_in_3, b.right_in_2, b.right_in_1, b.right_in_0} = rand_elem(1'b0);
    send(b);
  endtask

  task automatic run_perm(elem_t l, elem_t r);
    in_beat_t b;
    b.cmd = CMD_PERMUTE;
    b.key_index = 6'($urandom);
    {b.left_in_3, b.left_in_2, b.left_in_1, b.left_in_0} = l;
    {b.right_in_3, b.right_in_2, b.right_in_1, b.right_in_0} = r;
    send(b);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
  endtask

  // receiver, with one long stall once results start flowing
  initial begin
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (results_seen == 3) gap = LONG_HOLD;
      else gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
      results_seen++;
    end
  end

  initial begin
    elem_t ones;
    ones = '1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill the key store, extremes in the first slots
    load_key(6'd0, '0);
    load_key(6'd1, MODULUS - 1);
    load_key(6'd2, MODULUS);
    load_key(6'd3, ones);
    for (int i = 4; i < KEY_SLOTS; i++) load_key(6'(i), rand_elem($urandom_range(0, 3) != 0));

    // directed
    run_perm('0, '0);
    run_perm(MODULUS - 1, MODULUS - 1);
    run_perm(MODULUS, '0);
    run_perm('0, MODULUS);
    run_perm(ones, ones);
    load_key(6'd62, rand_elem(1'b0));
    load_key(6'd63, rand_elem(1'b0));
    load_key(6'd10, ones);
    run_perm(rand_elem(1'b1), rand_elem(1'b1));
    drain();

    // random mix: mostly key loads, a permute now and then
    for (int n = 0; n < ITEMS; n++) begin
      if (n % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (n == ITEMS / 2) drain();
      if ($urandom_range(0, 14) == 0) begin
        case ($urandom_range(0, 9))
          0: run_perm(rand_elem(1'b0), rand_elem(1'b1));
          1: run_perm(rand_elem(1'b1), rand_elem(1'b0));
          2: run_perm(MODULUS - 1, rand_elem(1'b1));
          default: run_perm(rand_elem(1'b1), rand_elem(1'b1));
        endcase
      end else begin
        load_key(6'($urandom_range(0, 63)), rand_elem($urandom_range(0, 1) != 0));
      end
    end
    drain();

    $display("covered %0d key loads and %0d permutations, %0d results checked",
             loads, permutes, results_seen);
    $display("including extreme and non-canonical elements and a long output stall");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
